// ----- rtl/nfha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared codes and controller/datapath interface types for the next-fit
// heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;
    localparam logic [1:0] ST_NULL     = 2'd3;

    typedef struct packed {
        logic ld_in;
        logic clr_step;
        logic rd_p;
        logic rd_zero;
        logic rd_cnxt;
        logic rd_h;
        logic p_cursor;
        logic p_zero;
        logic p_next;
        logic split_a;
        logic split_b;
        logic set_merged;
        logic fail;
        logic co_load;
        logic co_merge;
        logic co_adv;
        logic free_ok;
        logic set_null;
        logic set_notalloc;
    } dp_ctrl_t;

    typedef struct packed {
        logic       clr_last;
        logic       cursor_ok;
        logic       fit;
        logic       walk_end;
        logic       co_exit;
        logic       co_both_free;
        logic       off_zero;
        logic       off_bad;
        logic       hdr_used;
        logic       merged;
        logic [1:0] cmd;
    } dp_stat_t;

endpackage

// ----- rtl/nfha_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfha_datapath
// Header memory, walk pointers, search cursor and result registers.
// ----------------------------------------------------------------------------
module nfha_datapath
    import nfha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_ctrl_t    ctrl,
    output dp_stat_t    stat,
    input  logic [1:0]  command,
    input  logic [12:0] request_bytes,
    input  logic [11:0] block_offset,
    output logic [1:0]  status,
    output logic [11:0] payload_offset,
    output logic        merged
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int PW = AW + 2;
    localparam int CW = (PW > 14) ? PW : 14;
    localparam int OW = (PW > 12) ? PW : 12;
    localparam logic [PW-1:0] HDR  = PW'(HEADER_BYTES);
    localparam logic [PW-1:0] HEAP = PW'(HEAP_BYTES);
    localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

    logic [AW:0]    mem [HEAP_BYTES];
    logic [AW:0]    rdata_reg;
    logic           rd_en;
    logic [AW-1:0]  raddr;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [AW:0]    wdata;

    logic [1:0]     cmd_reg;
    logic [12:0]    req_reg;
    logic [11:0]    off_reg;
    logic [PW-1:0]  p_reg;
    logic [PW-1:0]  nxt_reg;
    logic [PW-1:0]  cur_reg;
    logic           cur_used_reg;
    logic [AW-1:0]  cur_size_reg;
    logic [PW-1:0]  cursor_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [1:0]     status_reg;
    logic [11:0]    pay_reg;
    logic           merged_reg;

    logic           r_used;
    logic [AW-1:0]  r_size;
    logic [PW-1:0]  p_next;
    logic [PW-1:0]  cnxt;
    logic [PW-1:0]  split_nxt;
    logic [OW-1:0]  pay_full;
    logic [OW-1:0]  h_full;
    logic [CW-1:0]  need;
    logic [AW-1:0]  req_s;

    assign r_used    = rdata_reg[AW];
    assign r_size    = rdata_reg[AW-1:0];
    assign p_next    = p_reg + HDR + PW'(r_size);
    assign cnxt      = cur_reg + HDR + PW'(cur_size_reg);
    assign req_s     = req_reg[AW-1:0];
    assign split_nxt = p_reg + HDR + PW'(req_s);
    assign pay_full  = OW'(p_reg + HDR);
    assign h_full    = OW'(off_reg) - OW'(HEADER_BYTES);
    assign need      = CW'(req_reg) + CW'(HEADER_BYTES);

    assign stat.clr_last     = (clr_cnt_reg == AW'(HEAP_BYTES - 1));
    assign stat.cursor_ok    = (cursor_reg + HDR <= HEAP);
    assign stat.fit          = !r_used && (CW'(r_size) >= need);
    assign stat.walk_end     = (p_next + HDR >= HEAP);
    assign stat.co_exit      = (cur_reg + HDR > HEAP) || (cnxt + HDR > HEAP);
    assign stat.co_both_free = !cur_used_reg && !r_used;
    assign stat.off_zero     = (off_reg == 12'd0);
    assign stat.off_bad      = (off_reg < 12'(HEADER_BYTES)) || (h_full >= OW'(HEAP_BYTES));
    assign stat.hdr_used     = r_used;
    assign stat.merged       = merged_reg;
    assign stat.cmd          = cmd_reg;

    always_comb
    begin
        rd_en = 1'b1;
        raddr = '0;
        if (ctrl.rd_p)
        begin
            raddr = p_reg[AW-1:0];
        end
        else if (ctrl.rd_cnxt)
        begin
            raddr = cnxt[AW-1:0];
        end
        else if (ctrl.rd_h)
        begin
            raddr = h_full[AW-1:0];
        end
        else if (!ctrl.rd_zero)
        begin
            rd_en = 1'b0;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (ctrl.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = (clr_cnt_reg == '0) ? {1'b0, INIT_SIZE} : '0;
        end
        else if (ctrl.split_a)
        begin
            we    = 1'b1;
            waddr = p_reg[AW-1:0];
            wdata = {1'b1, req_s};
        end
        else if (ctrl.split_b)
        begin
            we    = (nxt_reg < HEAP);
            waddr = nxt_reg[AW-1:0];
            wdata = {1'b0, r_size - req_s - AW'(HEADER_BYTES)};
        end
        else if (ctrl.co_merge)
        begin
            we    = 1'b1;
            waddr = cur_reg[AW-1:0];
            wdata = {cur_used_reg, cur_size_reg + r_size + AW'(HEADER_BYTES)};
        end
        else if (ctrl.free_ok)
        begin
            we    = 1'b1;
            waddr = h_full[AW-1:0];
            wdata = {1'b0, r_size};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            clr_cnt_reg <= '0;
            merged_reg  <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            if (ctrl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (ctrl.ld_in)
            begin
                merged_reg <= 1'b0;
                status_reg <= ST_OK;
            end
            if (ctrl.set_merged)
            begin
                merged_reg <= 1'b1;
            end
            if (ctrl.split_a)
            begin
                cursor_reg <= split_nxt;
            end
            if (ctrl.fail)
            begin
                cursor_reg <= '0;
                status_reg <= ST_NOMEM;
            end
            if (ctrl.set_null)
            begin
                status_reg <= ST_NULL;
            end
            if (ctrl.set_notalloc)
            begin
                status_reg <= ST_NOTALLOC;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_in)
        begin
            cmd_reg <= command;
            req_reg <= request_bytes;
            off_reg <= block_offset;
            pay_reg <= '0;
        end
        if (ctrl.p_cursor)
        begin
            p_reg <= cursor_reg;
        end
        else if (ctrl.p_zero)
        begin
            p_reg <= '0;
        end
        else if (ctrl.p_next)
        begin
            p_reg <= p_next;
        end
        if (ctrl.split_a)
        begin
            nxt_reg <= split_nxt;
            pay_reg <= pay_full[11:0];
        end
        if (ctrl.co_load)
        begin
            cur_reg      <= '0;
            cur_used_reg <= r_used;
            cur_size_reg <= r_size;
        end
        else if (ctrl.co_merge)
        begin
            cur_size_reg <= cur_size_reg + r_size + AW'(HEADER_BYTES);
        end
        else if (ctrl.co_adv)
        begin
            cur_reg      <= cnxt;
            cur_used_reg <= r_used;
            cur_size_reg <= r_size;
        end
    end

    assign status         = status_reg;
    assign payload_offset = pay_reg;
    assign merged         = merged_reg;

endmodule

// ----- rtl/nfha_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfha_controller
// Sequencer for clearing, next-fit search, coalescing, split and free.
// ----------------------------------------------------------------------------
module nfha_controller
    import nfha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy,
    output logic     done
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_ARD   = 4'd3;
    localparam logic [3:0] S_AEV   = 4'd4;
    localparam logic [3:0] S_SPA   = 4'd5;
    localparam logic [3:0] S_SPB   = 4'd6;
    localparam logic [3:0] S_CO0   = 4'd7;
    localparam logic [3:0] S_COLD  = 4'd8;
    localparam logic [3:0] S_COCHK = 4'd9;
    localparam logic [3:0] S_COEV  = 4'd10;
    localparam logic [3:0] S_FCHK  = 4'd11;
    localparam logic [3:0] S_FEV   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.ld_in = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.cmd == CMD_ALLOC || stat.cmd == CMD_REALLOC)
                begin
                    if (stat.cursor_ok)
                    begin
                        ctrl.p_cursor = 1'b1;
                        state_next    = S_ARD;
                    end
                    else
                    begin
                        state_next = S_CO0;
                    end
                end
                else if (stat.cmd == CMD_FREE)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ARD:
            begin
                ctrl.rd_p  = 1'b1;
                state_next = S_AEV;
            end
            S_AEV:
            begin
                if (stat.fit)
                begin
                    state_next = S_SPA;
                end
                else
                begin
                    ctrl.p_next = 1'b1;
                    if (!stat.walk_end)
                    begin
                        state_next = S_ARD;
                    end
                    else if (!stat.merged)
                    begin
                        state_next = S_CO0;
                    end
                    else
                    begin
                        ctrl.fail  = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_SPA:
            begin
                ctrl.split_a = 1'b1;
                state_next   = S_SPB;
            end
            S_SPB:
            begin
                ctrl.split_b = 1'b1;
                state_next   = (stat.cmd == CMD_REALLOC) ? S_FCHK : S_DONE;
            end
            S_CO0:
            begin
                ctrl.rd_zero    = 1'b1;
                ctrl.set_merged = 1'b1;
                state_next      = S_COLD;
            end
            S_COLD:
            begin
                ctrl.co_load = 1'b1;
                state_next   = S_COCHK;
            end
            S_COCHK:
            begin
                if (stat.co_exit)
                begin
                    ctrl.p_zero = 1'b1;
                    state_next  = S_ARD;
                end
                else
                begin
                    ctrl.rd_cnxt = 1'b1;
                    state_next   = S_COEV;
                end
            end
            S_COEV:
            begin
                if (stat.co_both_free)
                begin
                    ctrl.co_merge = 1'b1;
                end
                else
                begin
                    ctrl.co_adv = 1'b1;
                end
                state_next = S_COCHK;
            end
            S_FCHK:
            begin
                if (stat.off_zero)
                begin
                    ctrl.set_null = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.off_bad)
                begin
                    ctrl.set_notalloc = 1'b1;
                    state_next        = S_DONE;
                end
                else
                begin
                    ctrl.rd_h  = 1'b1;
                    state_next = S_FEV;
                end
            end
            S_FEV:
            begin
                if (stat.hdr_used)
                begin
                    ctrl.free_ok = 1'b1;
                end
                else
                begin
                    ctrl.set_notalloc = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ----- rtl/next_fit_heap_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_core
// Next-fit boundary-tag allocator over a header memory, one header per byte
// offset.
//
// Channel   Handshake              Fields
// input     start && !busy         command, request_bytes, block_offset
// result    done (one cycle)       status, payload_offset, merged
//
// An allocate walks the header chain through S_ARD and S_AEV for each header
// (one memory read port); a coalescing pass steps through S_COCHK and S_COEV
// for each header visited.
// After reset a clearing pass writes all HEAP_BYTES header entries with busy high.
// The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator_core
    import nfha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [12:0] request_bytes,
    input  logic [11:0] block_offset,
    output logic        done,
    output logic [1:0]  status,
    output logic [11:0] payload_offset,
    output logic        merged
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    nfha_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    nfha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .command        (command),
        .request_bytes  (request_bytes),
        .block_offset   (block_offset),
        .status         (status),
        .payload_offset (payload_offset),
        .merged         (merged)
    );

endmodule

// ----- rtl/nfha_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfha_checker
// Port-level checks on the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module nfha_checker
    import nfha_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [11:0] payload_offset
);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("transfer accepted without going busy");

    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NOMEM) |-> (payload_offset == 12'd0))
        else $error("out of memory with non-zero offset");

endmodule

bind next_fit_heap_allocator_core nfha_checker u_nfha_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .payload_offset (payload_offset)
);
